[rtl/core/voxel_rotate_project_top_macros.svh]
// Assertion helpers for the voxel projection core.
`ifndef VOXEL_ROTATE_PROJECT_TOP_MACROS_SVH
`define VOXEL_ROTATE_PROJECT_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define VRP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define VRP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VRP_ASSERT_IMP(label, ante, cons, msg)
`define VRP_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

[rtl/core/vrp_pkg.sv]
`timescale 1ns / 1ps
package vrp_pkg;

  localparam int SCREEN_W   = 800;
  localparam int SCREEN_H   = 600;
  localparam int BASE_SCALE = 10;
  localparam int ORIGIN_X   = SCREEN_W / 2;
  localparam int ORIGIN_Y   = SCREEN_H / 2;

  // field widths
  localparam int VOX_W      = 8;
  localparam int DIM_W      = 8;
  localparam int TRIG_W     = 16;
  localparam int COL_W      = 8;
  localparam int CIDX_W     = 4;
  localparam int POS_W      = 14;
  localparam int SIZE_W     = 5;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // reset values of the registers
  localparam int RST_VOLUME_DIM = 16;
  localparam int RST_COSINE     = 16384;
  localparam int RST_SINE       = 0;

  // centred coordinates in half units, rotated x with weight 2^-15
  localparam int CW     = VOX_W + 2;
  localparam int PROD_W = CW + TRIG_W;
  localparam int RX_W   = PROD_W + 1;

  // scale in Q12.8: SCALE_ONE + floor(SCALE_ONE * z / depth)
  localparam int SCALE_FRAC = 8;
  localparam int SCALE_ONE  = BASE_SCALE * (2 ** SCALE_FRAC);
  localparam int NUM_MAX    = SCALE_ONE * ((2 ** VOX_W) - 1);
  localparam int NUM_W      = $clog2(NUM_MAX + 1);
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = (NUM_W + DIV_STEP - 1) / DIV_STEP;
  localparam int QUO_W      = DIV_STAGES * DIV_STEP;
  localparam int SCALE_W    = $clog2(SCALE_ONE + NUM_MAX + 1);
  localparam int SIZE_INT_W = SCALE_W - SCALE_FRAC;

  localparam int FRAC_X = 23;
  localparam int FRAC_Y = 9;
  localparam int PX_W   = RX_W + SCALE_W + 1;
  localparam int PY_W   = CW + SCALE_W + 1;

  localparam int POS_MAX  = (2 ** (POS_W - 1)) - 1;
  localparam int POS_MIN  = -(2 ** (POS_W - 1));
  localparam int SIZE_MAX = (2 ** SIZE_W) - 1;

  // front, divider stages, then scale, multiply and output stages
  localparam int NSTAGE = DIV_STAGES + 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLUME_WIDTH,
    REG_VOLUME_HEIGHT,
    REG_VOLUME_DEPTH,
    REG_ROT_COSINE,
    REG_ROT_SINE
  } cfg_reg_t;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [DIM_W-1:0]    rem;
    logic [DIV_STEP-1:0] quo;
  } div_res_t;

  // restoring division, DIV_STEP quotient bits; rem_in < den on entry
  function automatic div_res_t div_step(input logic [DIM_W-1:0] rem_in,
                                        input logic [DIV_STEP-1:0] bits,
                                        input logic [DIM_W-1:0] den);
    div_res_t res;
    logic [DIM_W:0] trial;
    logic [DIM_W-1:0] rem;
    rem = rem_in;
    res.quo = '0;
    for (int i = DIV_STEP - 1; i >= 0; i--) begin
      trial = {rem, bits[i]};
      if (trial >= {1'b0, den}) begin
        res.quo[i] = 1'b1;
        trial = trial - {1'b0, den};
      end
      rem = trial[DIM_W-1:0];
    end
    res.rem = rem;
    return res;
  endfunction

  // 16-colour VGA palette
  function automatic rgb_t palette_lookup(input logic [CIDX_W-1:0] idx);
    rgb_t c;
    case (idx)
      4'd0:    c = {8'h00, 8'h00, 8'h00};
      4'd1:    c = {8'h00, 8'h00, 8'hAA};
      4'd2:    c = {8'h00, 8'hAA, 8'h00};
      4'd3:    c = {8'h00, 8'hAA, 8'hAA};
      4'd4:    c = {8'hAA, 8'h00, 8'h00};
      4'd5:    c = {8'hAA, 8'h00, 8'hAA};
      4'd6:    c = {8'hAA, 8'h55, 8'h00};
      4'd7:    c = {8'hAA, 8'hAA, 8'hAA};
      4'd8:    c = {8'h55, 8'h55, 8'h55};
      4'd9:    c = {8'h55, 8'h55, 8'hFF};
      4'd10:   c = {8'h55, 8'hFF, 8'h55};
      4'd11:   c = {8'h55, 8'hFF, 8'hFF};
      4'd12:   c = {8'hFF, 8'h55, 8'h55};
      4'd13:   c = {8'hFF, 8'h55, 8'hFF};
      4'd14:   c = {8'hFF, 8'hFF, 8'h55};
      4'd15:   c = {8'hFF, 8'hFF, 8'hFF};
      default: c = {8'h00, 8'h00, 8'h00};
    endcase
    return c;
  endfunction

endpackage

[rtl/core/vrp_if.sv]
`timescale 1ns / 1ps
interface vrp_vox_if;
  import vrp_pkg::*;
  logic             valid;
  logic             ready;
  logic [VOX_W-1:0] vox_x;
  logic [VOX_W-1:0] vox_y;
  logic [VOX_W-1:0] vox_z;
  logic [COL_W-1:0] voxel_color;

  modport source (output valid, vox_x, vox_y, vox_z, voxel_color, input ready);
  modport sink   (input valid, vox_x, vox_y, vox_z, voxel_color, output ready);
endinterface

interface vrp_proj_if;
  import vrp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [SIZE_W-1:0]       square_size;
  logic [COL_W-1:0]        red;
  logic [COL_W-1:0]        green;
  logic [COL_W-1:0]        blue;

  modport source (output valid, pos_x, pos_y, square_size, red, green, blue, input ready);
  modport sink   (input valid, pos_x, pos_y, square_size, red, green, blue, output ready);
endinterface

[rtl/core/vrp_front.sv]
`timescale 1ns / 1ps
module vrp_front (
  input  logic                           clk,
  input  logic                           load,
  input  logic [vrp_pkg::VOX_W-1:0]      vox_x,
  input  logic [vrp_pkg::VOX_W-1:0]      vox_y,
  input  logic [vrp_pkg::VOX_W-1:0]      vox_z,
  input  logic [vrp_pkg::COL_W-1:0]      voxel_color,
  input  logic [vrp_pkg::DIM_W-1:0]      vol_width,
  input  logic [vrp_pkg::DIM_W-1:0]      vol_height,
  input  logic [vrp_pkg::DIM_W-1:0]      vol_depth,
  output logic signed [vrp_pkg::CW-1:0]  cx,
  output logic signed [vrp_pkg::CW-1:0]  cy,
  output logic signed [vrp_pkg::CW-1:0]  cz,
  output logic [vrp_pkg::QUO_W-1:0]      num,
  output logic [vrp_pkg::CIDX_W-1:0]     cidx
);
  import vrp_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      cx   <= $signed({1'b0, vox_x, 1'b0}) - $signed({2'b00, vol_width});
      cy   <= $signed({1'b0, vox_y, 1'b0}) - $signed({2'b00, vol_height});
      cz   <= $signed({1'b0, vox_z, 1'b0}) - $signed({2'b00, vol_depth});
      // dividend for the depth factor, a constant multiply
      num  <= QUO_W'(vox_z) * QUO_W'(SCALE_ONE);
      cidx <= voxel_color[CIDX_W-1:0];
    end
  end

endmodule

[rtl/core/vrp_rotate.sv]
`timescale 1ns / 1ps
module vrp_rotate (
  input  logic                              clk,
  input  logic [vrp_pkg::NSTAGE-1:0]        load,
  input  logic signed [vrp_pkg::CW-1:0]     cx,
  input  logic signed [vrp_pkg::CW-1:0]     cy,
  input  logic signed [vrp_pkg::CW-1:0]     cz,
  input  logic [vrp_pkg::CIDX_W-1:0]        cidx,
  input  logic signed [vrp_pkg::TRIG_W-1:0] cosv,
  input  logic signed [vrp_pkg::TRIG_W-1:0] sinv,
  output logic signed [vrp_pkg::RX_W-1:0]   rx_out,
  output logic signed [vrp_pkg::CW-1:0]     cy_out,
  output logic [vrp_pkg::CIDX_W-1:0]        cidx_out
);
  import vrp_pkg::*;

  logic signed [PROD_W-1:0] pc;
  logic signed [PROD_W-1:0] ps;
  logic signed [CW-1:0]     cy_d   [1:DIV_STAGES];
  logic [CIDX_W-1:0]        cidx_d [1:DIV_STAGES];
  logic signed [RX_W-1:0]   rx_d   [2:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (load[1]) begin
      pc        <= cx * cosv;
      ps        <= cz * sinv;
      cy_d[1]   <= cy;
      cidx_d[1] <= cidx;
    end
    if (load[2]) begin
      rx_d[2] <= RX_W'(pc) - RX_W'(ps);
    end
    for (int s = 2; s <= DIV_STAGES; s++) begin
      if (load[s]) begin
        cy_d[s]   <= cy_d[s-1];
        cidx_d[s] <= cidx_d[s-1];
      end
    end
    // wait alongside the divider
    for (int s = 3; s <= DIV_STAGES; s++) begin
      if (load[s]) begin
        rx_d[s] <= rx_d[s-1];
      end
    end
  end

  assign rx_out   = rx_d[DIV_STAGES];
  assign cy_out   = cy_d[DIV_STAGES];
  assign cidx_out = cidx_d[DIV_STAGES];

endmodule

[rtl/core/vrp_divider.sv]
`timescale 1ns / 1ps
module vrp_divider (
  input  logic                         clk,
  input  logic [vrp_pkg::NSTAGE-1:0]   load,
  input  logic [vrp_pkg::QUO_W-1:0]    num,
  input  logic [vrp_pkg::DIM_W-1:0]    den,
  output logic [vrp_pkg::QUO_W-1:0]    quo
);
  import vrp_pkg::*;

  logic [DIM_W-1:0] rem_d [1:DIV_STAGES-1];
  logic [QUO_W-1:0] num_d [1:DIV_STAGES-1];
  logic [QUO_W-1:0] quo_d [1:DIV_STAGES];

  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_stage
    localparam int HI = QUO_W - 1 - (s - 1) * DIV_STEP;
    logic [DIM_W-1:0] rem_in;
    logic [QUO_W-1:0] num_in;
    logic [QUO_W-1:0] quo_in;
    logic [QUO_W-1:0] quo_new;
    div_res_t         res;

    if (s == 1) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_d[s-1];
      assign num_in = num_d[s-1];
      assign quo_in = quo_d[s-1];
    end

    assign res = div_step(rem_in, num_in[HI -: DIV_STEP], den);

    always_comb begin
      quo_new = quo_in;
      quo_new[HI -: DIV_STEP] = res.quo;
    end

    always_ff @(posedge clk) begin
      if (load[s]) begin
        quo_d[s] <= quo_new;
      end
    end

    // last stage keeps only the quotient
    if (s < DIV_STAGES) begin : g_carry
      always_ff @(posedge clk) begin
        if (load[s]) begin
          rem_d[s] <= res.rem;
          num_d[s] <= num_in;
        end
      end
    end
  end

  assign quo = quo_d[DIV_STAGES];

endmodule

[rtl/core/vrp_project.sv]
`timescale 1ns / 1ps
module vrp_project (
  input  logic                              clk,
  input  logic [vrp_pkg::NSTAGE-1:0]        load,
  input  logic [vrp_pkg::QUO_W-1:0]         quo,
  input  logic signed [vrp_pkg::RX_W-1:0]   rx,
  input  logic signed [vrp_pkg::CW-1:0]     cy,
  input  logic [vrp_pkg::CIDX_W-1:0]        cidx,
  output logic signed [vrp_pkg::POS_W-1:0]  pos_x,
  output logic signed [vrp_pkg::POS_W-1:0]  pos_y,
  output logic [vrp_pkg::SIZE_W-1:0]        square_size,
  output logic [vrp_pkg::COL_W-1:0]         red,
  output logic [vrp_pkg::COL_W-1:0]         green,
  output logic [vrp_pkg::COL_W-1:0]         blue
);
  import vrp_pkg::*;

  localparam int ST_A = DIV_STAGES + 1;
  localparam int ST_B = DIV_STAGES + 2;
  localparam int ST_C = DIV_STAGES + 3;

  localparam logic signed [PX_W-1:0] OFF_X  = PX_W'(ORIGIN_X) << FRAC_X;
  localparam logic signed [PY_W-1:0] OFF_Y  = PY_W'(ORIGIN_Y) << FRAC_Y;
  localparam logic signed [PX_W-1:0] BIAS_X = (PX_W'(1) << FRAC_X) - PX_W'(1);
  localparam logic signed [PY_W-1:0] BIAS_Y = (PY_W'(1) << FRAC_Y) - PY_W'(1);
  localparam logic signed [PX_W-1:0] HI_X   = PX_W'(POS_MAX);
  localparam logic signed [PX_W-1:0] LO_X   = PX_W'(POS_MIN);
  localparam logic signed [PY_W-1:0] HI_Y   = PY_W'(POS_MAX);
  localparam logic signed [PY_W-1:0] LO_Y   = PY_W'(POS_MIN);

  // stage A: scale and square size
  logic [SCALE_W-1:0]    scale_c;
  logic [SIZE_INT_W-1:0] size_int;
  logic [SIZE_W-1:0]     size_c;
  logic [SCALE_W-1:0]    scale_a;
  logic [SIZE_W-1:0]     size_a;
  logic signed [RX_W-1:0] rx_a;
  logic signed [CW-1:0]   cy_a;
  logic [CIDX_W-1:0]      cidx_a;

  assign scale_c  = SCALE_W'(SCALE_ONE) + SCALE_W'(quo);
  assign size_int = scale_c[SCALE_W-1:SCALE_FRAC];
  assign size_c   = (size_int > SIZE_INT_W'(SIZE_MAX)) ? SIZE_W'(SIZE_MAX)
                                                       : size_int[SIZE_W-1:0];

  // stage B: products
  logic signed [PX_W-1:0] prod_x;
  logic signed [PY_W-1:0] prod_y;
  logic [SIZE_W-1:0]      size_b;
  logic [CIDX_W-1:0]      cidx_b;

  // stage C: offset, truncate toward zero, saturate
  logic signed [PX_W-1:0]  sum_x;
  logic signed [PX_W-1:0]  tr_x;
  logic signed [PY_W-1:0]  sum_y;
  logic signed [PY_W-1:0]  tr_y;
  logic signed [POS_W-1:0] pos_x_c;
  logic signed [POS_W-1:0] pos_y_c;
  rgb_t                    rgb_c;

  assign sum_x = prod_x + OFF_X;
  assign sum_y = prod_y + OFF_Y;
  assign tr_x  = (sum_x[PX_W-1] ? sum_x + BIAS_X : sum_x) >>> FRAC_X;
  assign tr_y  = (sum_y[PY_W-1] ? sum_y + BIAS_Y : sum_y) >>> FRAC_Y;

  assign pos_x_c = (tr_x > HI_X) ? POS_W'(POS_MAX) :
                   (tr_x < LO_X) ? POS_W'(POS_MIN) : tr_x[POS_W-1:0];
  assign pos_y_c = (tr_y > HI_Y) ? POS_W'(POS_MAX) :
                   (tr_y < LO_Y) ? POS_W'(POS_MIN) : tr_y[POS_W-1:0];

  assign rgb_c = palette_lookup(cidx_b);

  always_ff @(posedge clk) begin
    if (load[ST_A]) begin
      scale_a <= scale_c;
      size_a  <= size_c;
      rx_a    <= rx;
      cy_a    <= cy;
      cidx_a  <= cidx;
    end
    if (load[ST_B]) begin
      prod_x <= rx_a * $signed({1'b0, scale_a});
      prod_y <= cy_a * $signed({1'b0, scale_a});
      size_b <= size_a;
      cidx_b <= cidx_a;
    end
    if (load[ST_C]) begin
      pos_x       <= pos_x_c;
      pos_y       <= pos_y_c;
      square_size <= size_b;
      red         <= rgb_c.red;
      green       <= rgb_c.green;
      blue        <= rgb_c.blue;
    end
  end

endmodule

[rtl/core/voxel_rotate_project_top.sv]
// Channel  Dir  Handshake    Payload
// vox      in   valid/ready  vox_x, vox_y, vox_z, voxel_color
// proj     out  valid/ready  pos_x, pos_y, square_size, red, green, blue
// cfg      in   cfg_we       cfg_index, cfg_data (write only)
//
// One item per cycle sustained while proj.ready stays high; stages from acceptance to proj.valid:
// front, five divider stages (4 quotient bits each), scale, multiply, output.
// Empty voxels (colour 0) are taken and dropped at the front stage.
// Reset (rst, synchronous) clears the stage valid bits and loads register defaults.
// Each stage holds while full and blocked; bubbles close up, so vox.ready
// drops only when every stage holds an item.
`timescale 1ns / 1ps
`include "voxel_rotate_project_top_macros.svh"
module voxel_rotate_project_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [vrp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vrp_pkg::CFG_DATA_W-1:0]     cfg_data,
  vrp_vox_if.sink                            vox,
  vrp_proj_if.source                         proj
);
  import vrp_pkg::*;

  logic [DIM_W-1:0]         vol_width;
  logic [DIM_W-1:0]         vol_height;
  logic [DIM_W-1:0]         vol_depth;
  logic [DIM_W-1:0]         depth_eff;
  logic signed [TRIG_W-1:0] rot_cos;
  logic signed [TRIG_W-1:0] rot_sin;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] ready;

  logic signed [CW-1:0]   cx_f;
  logic signed [CW-1:0]   cy_f;
  logic signed [CW-1:0]   cz_f;
  logic [QUO_W-1:0]       num_f;
  logic [CIDX_W-1:0]      cidx_f;
  logic signed [RX_W-1:0] rx_r;
  logic signed [CW-1:0]   cy_r;
  logic [CIDX_W-1:0]      cidx_r;
  logic [QUO_W-1:0]       quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      vol_width  <= DIM_W'(RST_VOLUME_DIM);
      vol_height <= DIM_W'(RST_VOLUME_DIM);
      vol_depth  <= DIM_W'(RST_VOLUME_DIM);
      rot_cos    <= TRIG_W'(RST_COSINE);
      rot_sin    <= TRIG_W'(RST_SINE);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VOLUME_WIDTH:  vol_width  <= cfg_data[DIM_W-1:0];
        REG_VOLUME_HEIGHT: vol_height <= cfg_data[DIM_W-1:0];
        REG_VOLUME_DEPTH:  vol_depth  <= cfg_data[DIM_W-1:0];
        REG_ROT_COSINE:    rot_cos    <= cfg_data[TRIG_W-1:0];
        REG_ROT_SINE:      rot_sin    <= cfg_data[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // zero depth behaves as one
  assign depth_eff = (vol_depth == '0) ? DIM_W'(1) : vol_depth;

  // a stage loads when empty or when its successor loads
  assign ready[NSTAGE-1] = !vld[NSTAGE-1] || proj.ready;
  for (genvar i = 0; i < NSTAGE - 1; i++) begin : g_ready
    assign ready[i] = !vld[i] || ready[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ready[0]) begin
        vld[0] <= vox.valid && (vox.voxel_color != '0);
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (ready[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign vox.ready  = ready[0];
  assign proj.valid = vld[NSTAGE-1];

  vrp_front u_front (
    .clk         (clk),
    .load        (ready[0]),
    .vox_x       (vox.vox_x),
    .vox_y       (vox.vox_y),
    .vox_z       (vox.vox_z),
    .voxel_color (vox.voxel_color),
    .vol_width   (vol_width),
    .vol_height  (vol_height),
    .vol_depth   (depth_eff),
    .cx          (cx_f),
    .cy          (cy_f),
    .cz          (cz_f),
    .num         (num_f),
    .cidx        (cidx_f)
  );

  vrp_rotate u_rotate (
    .clk      (clk),
    .load     (ready),
    .cx       (cx_f),
    .cy       (cy_f),
    .cz       (cz_f),
    .cidx     (cidx_f),
    .cosv     (rot_cos),
    .sinv     (rot_sin),
    .rx_out   (rx_r),
    .cy_out   (cy_r),
    .cidx_out (cidx_r)
  );

  vrp_divider u_divider (
    .clk  (clk),
    .load (ready),
    .num  (num_f),
    .den  (depth_eff),
    .quo  (quo)
  );

  vrp_project u_project (
    .clk         (clk),
    .load        (ready),
    .quo         (quo),
    .rx          (rx_r),
    .cy          (cy_r),
    .cidx        (cidx_r),
    .pos_x       (proj.pos_x),
    .pos_y       (proj.pos_y),
    .square_size (proj.square_size),
    .red         (proj.red),
    .green       (proj.green),
    .blue        (proj.blue)
  );

  `VRP_ASSERT_NXT(a_empty_dropped, vox.valid && vox.ready && (vox.voxel_color == '0), !vld[0], "empty voxel entered the pipeline")
  `VRP_ASSERT_IMP(a_block_only_full, !vox.ready, &vld, "input blocked with a free stage")
  `VRP_ASSERT_IMP(a_size_floor, proj.valid, (proj.square_size >= SIZE_W'(BASE_SCALE)) || (proj.square_size == SIZE_W'(SIZE_MAX)), "square size below base scale")

endmodule
